// File: hw/rtl/swcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcd_pkg: shared types and constants
// Request and result records, event codes, mode codes and limits used by
// the stopwatch / countdown / adjuster core.
// ----------------------------------------------------------------------------
package swcd_pkg;

	// event codes carried in the cmd field
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_TURN  = 2'd1;
	localparam logic [1:0] CMD_PRESS = 2'd2;

	// operating modes
	localparam logic [1:0] MODE_SW  = 2'd0;
	localparam logic [1:0] MODE_CD  = 2'd1;
	localparam logic [1:0] MODE_ADJ = 2'd2;

	localparam int unsigned CD_STEP_SECS  = 30;
	localparam int unsigned CD_MIN_SECS   = 30;
	localparam int unsigned CD_MAX_SECS   = 7200;
	localparam int unsigned CD_RESET_SECS = 60;
	localparam int unsigned MS_PER_SEC    = 1000;
	localparam int unsigned VAL_MAX       = 24'hFFFFFF;
	localparam int unsigned MODE_COUNT    = 3;

	localparam int unsigned CD_MS_W = 23; // holds CD_MAX_SECS * MS_PER_SEC

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        now_ms;
		logic signed [7:0]  delta;
	} in_t;

	typedef struct packed {
		logic [1:0]  mode_now;
		logic        is_running;
		logic [31:0] elapsed_out;
		logic [12:0] timer_setting;
		logic [23:0] adjust_value;
	} out_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_TURN,
		OP_PRESS,
		OP_NOP
	} op_kind_t;

	// classified request as passed from front to back
	typedef struct packed {
		op_kind_t           kind;
		logic [31:0]        now_ms;
		logic signed [7:0]  delta;
		logic signed [13:0] delta_secs; // delta * CD_STEP_SECS
		logic [1:0]         mode_step;  // delta modulo MODE_COUNT, non-negative
	} op_t;

endpackage : swcd_pkg
`default_nettype wire

// File: hw/rtl/swcd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcd_front: request classifier
// Decodes the event kind and precomputes the state-independent terms of
// an encoder turn.
// ----------------------------------------------------------------------------
module swcd_front (
	input  var swcd_pkg::in_t item,
	output var swcd_pkg::op_t op
);
	import swcd_pkg::*;

	// non-negative remainder of a signed byte by three
	function automatic logic [1:0] mod3_byte(input logic signed [7:0] d);
		logic [7:0] u;
		logic [3:0] s;
		begin
			// d + 128 is congruent to d - 1, so fold back with +1
			u = {~d[7], d[6:0]};
			s = 4'(u[1:0]) + 4'(u[3:2]) + 4'(u[5:4]) + 4'(u[7:6]) + 4'd1;
			if (s >= 4'd12) begin
				s = s - 4'd12;
			end else if (s >= 4'd9) begin
				s = s - 4'd9;
			end else if (s >= 4'd6) begin
				s = s - 4'd6;
			end else if (s >= 4'd3) begin
				s = s - 4'd3;
			end
			mod3_byte = s[1:0];
		end
	endfunction

	always_comb begin
		case (item.cmd)
			CMD_TICK:  op.kind = OP_TICK;
			CMD_TURN:  op.kind = OP_TURN;
			CMD_PRESS: op.kind = OP_PRESS;
			default:   op.kind = OP_NOP;
		endcase
		op.now_ms     = item.now_ms;
		op.delta      = item.delta;
		op.delta_secs = 14'(item.delta) * 14'(CD_STEP_SECS);
		op.mode_step  = mod3_byte(item.delta);
	end

endmodule : swcd_front
`default_nettype wire

// File: hw/rtl/swcd_opq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcd_opq: request queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module swcd_opq (
	input  var logic          clk,
	input  var logic          arst_n,
	input  var logic          wr_en,
	input  var swcd_pkg::op_t wr_op,
	output var logic          full,
	input  var logic          rd_en,
	output var swcd_pkg::op_t rd_op,
	output var logic          rd_valid
);
	import swcd_pkg::*;

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule : swcd_opq
`default_nettype wire

// File: hw/rtl/swcd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcd_back: event executor
// Applies one request per cycle to the mode state while the result queue has
// room and queues the snapshot of the state in a two-entry result queue.
// ----------------------------------------------------------------------------
module swcd_back (
	input  var logic           clk,
	input  var logic           arst_n,
	input  var logic           op_valid,
	input  var swcd_pkg::op_t  op,
	output var logic           op_take,
	output var logic           empty,
	input  var logic           pop,
	output var swcd_pkg::out_t result
);
	import swcd_pkg::*;

	logic [1:0]         mode_q;
	logic               run_q;
	logic [31:0]        start_q;
	logic [31:0]        elapsed_q;
	logic [31:0]        deadline_q;
	logic [12:0]        cd_secs_q;
	logic [CD_MS_W-1:0] cd_ms_q;
	logic [23:0]        held_q;

	logic [1:0]         mode_d;
	logic               run_d;
	logic [31:0]        start_d;
	logic [31:0]        elapsed_d;
	logic [31:0]        deadline_d;
	logic [12:0]        cd_secs_d;
	logic [23:0]        held_d;

	logic signed [15:0] cd_sum;
	logic [12:0]        cd_clamped;
	logic signed [25:0] held_sum;
	logic [23:0]        held_clamped;
	logic [31:0]        remain;

	out_t       res_q [2];
	logic       res_wr_q;
	logic       res_rd_q;
	logic [1:0] res_cnt_q;
	logic       res_push;
	logic       res_pop;

	assign empty    = (res_cnt_q == 2'd0);
	assign result   = res_q[res_rd_q];
	assign res_pop  = pop && !empty;
	assign op_take  = op_valid && (res_cnt_q != 2'd2);
	assign res_push = op_take;

	always_comb begin
		cd_sum = 16'(signed'({3'b000, cd_secs_q})) + 16'(op.delta_secs);
		if (cd_sum < signed'(16'(CD_MIN_SECS))) begin
			cd_clamped = 13'(CD_MIN_SECS);
		end else if (cd_sum > signed'(16'(CD_MAX_SECS))) begin
			cd_clamped = 13'(CD_MAX_SECS);
		end else begin
			cd_clamped = cd_sum[12:0];
		end

		held_sum = 26'(signed'({2'b00, held_q})) + 26'(op.delta);
		if (held_sum < 26'sd0) begin
			held_clamped = 24'd0;
		end else if (held_sum > 26'(VAL_MAX)) begin
			held_clamped = 24'(VAL_MAX);
		end else begin
			held_clamped = held_sum[23:0];
		end

		remain = deadline_q - op.now_ms;

		mode_d     = mode_q;
		run_d      = run_q;
		start_d    = start_q;
		elapsed_d  = elapsed_q;
		deadline_d = deadline_q;
		cd_secs_d  = cd_secs_q;
		held_d     = held_q;

		case (op.kind)
			OP_TICK: begin
				if (mode_q == MODE_SW && run_q) begin
					elapsed_d = op.now_ms - start_q;
				end
				// stop once the signed time left is zero or negative
				if (mode_q == MODE_CD && run_q && (remain == 32'd0 || remain[31])) begin
					run_d = 1'b0;
				end
			end
			OP_TURN: begin
				if (!run_q) begin
					case (mode_q)
						MODE_CD:  cd_secs_d = cd_clamped;
						MODE_ADJ: held_d    = held_clamped;
						default:  mode_d    = op.mode_step;
					endcase
				end
			end
			OP_PRESS: begin
				case (mode_q)
					MODE_SW: begin
						if (!run_q) begin
							start_d = op.now_ms - elapsed_q;
						end
						run_d = !run_q;
					end
					MODE_CD: begin
						if (!run_q) begin
							deadline_d = op.now_ms + 32'(cd_ms_q);
						end
						run_d = !run_q;
					end
					default: held_d = 24'd0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SW;
			run_q      <= 1'b0;
			start_q    <= 32'd0;
			elapsed_q  <= 32'd0;
			deadline_q <= 32'd0;
			cd_secs_q  <= 13'(CD_RESET_SECS);
			cd_ms_q    <= CD_MS_W'(CD_RESET_SECS * MS_PER_SEC);
			held_q     <= 24'd0;
			res_wr_q   <= 1'b0;
			res_rd_q   <= 1'b0;
			res_cnt_q  <= 2'd0;
		end else begin
			if (op_take) begin
				mode_q     <= mode_d;
				run_q      <= run_d;
				start_q    <= start_d;
				elapsed_q  <= elapsed_d;
				deadline_q <= deadline_d;
				cd_secs_q  <= cd_secs_d;
				// keep the length in ms ready for the next start
				cd_ms_q    <= CD_MS_W'(cd_secs_d) * CD_MS_W'(MS_PER_SEC);
				held_q     <= held_d;
			end
			if (res_push) begin
				res_wr_q <= ~res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= ~res_rd_q;
			end
			case ({res_push, res_pop})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q].mode_now      <= mode_d;
			res_q[res_wr_q].is_running    <= run_d;
			res_q[res_wr_q].elapsed_out   <= elapsed_d;
			res_q[res_wr_q].timer_setting <= cd_secs_d;
			res_q[res_wr_q].adjust_value  <= held_d;
		end
	end

endmodule : swcd_back
`default_nettype wire

// File: hw/rtl/stopwatch_countdown_toolbox_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stopwatch_countdown_toolbox_core: stopwatch, countdown and value adjuster
// Event machine with three modes driven by tick, encoder and select requests.
// ----------------------------------------------------------------------------
// Each request is a tick, an encoder turn or a select press stamped with the
// millisecond time; every accepted request yields exactly one result, the
// state snapshot after the event. Requests enter at push/full and results
// leave at empty/pop, both queue style. The block takes one request per
// cycle while neither queue is full; each request is registered in the
// request queue and its result, once the executor applies it, in the result
// queue, from which it is popped. The rate is set by the executor, which
// applies one request per cycle to the mode state while the result queue has
// room; the two-entry request and result queues let either side stall alone.
// ----------------------------------------------------------------------------
module stopwatch_countdown_toolbox_core (
	input  var logic           clk,
	input  var logic           arst_n,
	input  var logic           push,
	output var logic           full,
	input  var swcd_pkg::in_t  item,
	output var logic           empty,
	input  var logic           pop,
	output var swcd_pkg::out_t result
);
	import swcd_pkg::*;

	op_t  front_op;   // classified request from the front
	op_t  back_op;    // oldest queued request
	logic back_valid;
	logic back_take;
	logic enq;

	// accept a request only while the queue has room
	assign enq = push && !full;

	// classify the event and precompute the encoder terms
	swcd_front u_front (
		.item (item),
		.op   (front_op)
	);

	// hold classified requests until the executor can take them
	swcd_opq u_opq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (enq),
		.wr_op    (front_op),
		.full     (full),
		.rd_en    (back_take),
		.rd_op    (back_op),
		.rd_valid (back_valid)
	);

	// advance the mode state and queue one snapshot per request
	swcd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (back_valid),
		.op       (back_op),
		.op_take  (back_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule : stopwatch_countdown_toolbox_core
`default_nettype wire

// File: hw/rtl/swcd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swcd_checker: port-level checks
// Watches the result side of the core for state that must never appear.
// ----------------------------------------------------------------------------
module swcd_checker (
	input var logic           clk,
	input var logic           arst_n,
	input var logic           empty,
	input var logic           pop,
	input var swcd_pkg::out_t result
);
	import swcd_pkg::*;

	// timer length stays clamped
	a_timer_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.timer_setting >= 13'(CD_MIN_SECS) &&
			result.timer_setting <= 13'(CD_MAX_SECS)))
		else $error("timer setting out of range");

	// mode code three is never produced
	a_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.mode_now == MODE_SW || result.mode_now == MODE_CD ||
			result.mode_now == MODE_ADJ))
		else $error("illegal mode code");

	// adjuster mode is entered only stopped and never runs
	a_adj_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.mode_now == MODE_ADJ) |-> !result.is_running)
		else $error("adjuster mode shows running");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule : swcd_checker

bind stopwatch_countdown_toolbox_core swcd_checker u_swcd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
`default_nettype wire
